// ===== rtl/slt_pkg.sv =====
// shared constants, codes and types of the sorted list table
`default_nettype none
package slt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int VALUE_W     = 32;
    localparam int ACTION_W    = 2;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_ENTRIES);

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]         position;
    } item_t;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   found_index;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/slt_req_if.sv =====
// request channel carrying one operation item
`default_nettype none
interface slt_req_if;
    import slt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);
endinterface
`default_nettype wire

// ===== rtl/slt_rsp_if.sv =====
// response channel carrying one result item
`default_nettype none
interface slt_rsp_if;
    import slt_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [POS_W-1:0]   found_index;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output ok, output found_index, output count, input ready);
    modport sink   (input valid, input ok, input found_index, input count, output ready);
endinterface
`default_nettype wire

// ===== rtl/slt_cfg_if.sv =====
// configuration write channel for the capacity register
`default_nettype none
interface slt_cfg_if;
    import slt_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface
`default_nettype wire

// ===== rtl/sorted_list_table.sv =====
// top level of the sorted list table
// usage:
//   req carries one operation item: action (insert, search, delete), value, position
//   rsp returns exactly one result item per request: ok, found_index, count
//   cfg writes the capacity register; always ready, write only while the block is idle
// an accepted item is held in the item register; its result is registered when the execute
//   step commits; the entry cells compare all stored values at once and shift in that step,
//   and the controller takes one item at a time
// the next item is taken while the previous result still waits on rsp; if rsp stalls,
//   the execute step holds until the result register frees
// reset: table empty (count 0), capacity 16, no result pending
// a full table or a lowered capacity refuses inserts with ok low and the table unchanged
`default_nettype none
module sorted_list_table (
    input  wire logic clk,
    input  wire logic rst_n,
    slt_req_if.sink   req,
    slt_rsp_if.source rsp,
    slt_cfg_if.sink   cfg
);
    import slt_pkg::*;

    dp_cmd_t cmd;
    item_t   item_in;
    result_t result;

    assign item_in.action   = req.action;
    assign item_in.value    = req.value;
    assign item_in.position = req.position;

    assign cfg.ready = 1'b1;

    slt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    slt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item_in  (item_in),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.capacity),
        .result   (result)
    );

    assign rsp.ok          = result.ok;
    assign rsp.found_index = result.found_index;
    assign rsp.count       = result.count;
endmodule
`default_nettype wire

// ===== rtl/slt_ctrl.sv =====
// controller state machine sequencing accept, execute and result hand-off
`default_nettype none
module slt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output slt_pkg::dp_cmd_t     cmd
);
    import slt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic slot_free;

    assign req_ready  = (state_reg == ST_IDLE);
    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign cmd.load   = req_valid && req_ready;
    assign cmd.commit = (state_reg == ST_EXEC) && slot_free;
    assign rsp_valid  = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/slt_dp.sv =====
// datapath: item register, entry cells with parallel compare and shift, result register
`default_nettype none
module slt_dp (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire slt_pkg::dp_cmd_t         cmd,
    input  wire slt_pkg::item_t           item_in,
    input  wire logic                     cfg_we,
    input  wire logic [slt_pkg::CAP_W-1:0] cfg_data,
    output slt_pkg::result_t              result
);
    import slt_pkg::*;

    item_t                      item_reg;
    result_t                    result_reg;
    result_t                    result_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic [CAP_W-1:0]           capacity_reg;
    logic signed [VALUE_W-1:0]  entries_reg  [MAX_ENTRIES];
    logic signed [VALUE_W-1:0]  entries_next [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0]     occupied;
    logic [MAX_ENTRIES-1:0]     below;
    logic [MAX_ENTRIES-1:0]     match;
    logic [CAP_W-1:0]           eff_cap;
    logic                       ins_ok;
    logic                       del_ok;
    logic                       hit;
    logic [POS_W-1:0]           hit_index;

    assign eff_cap = (capacity_reg > CAP_LIMIT) ? CAP_LIMIT : capacity_reg;
    assign ins_ok  = (item_reg.action == ACT_INSERT) && (count_reg < COUNT_W'(eff_cap));
    assign del_ok  = (item_reg.action == ACT_DELETE)
                     && (COUNT_W'(item_reg.position) < count_reg);

    always_comb
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            occupied[j] = COUNT_W'(j) < count_reg;
            below[j]    = occupied[j] && (entries_reg[j] < item_reg.value);
            match[j]    = occupied[j] && (entries_reg[j] == item_reg.value);
        end
    end

    // lowest matching cell
    always_comb
    begin
        hit       = |match;
        hit_index = '0;
        for (int j = MAX_ENTRIES - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit_index = POS_W'(j);
            end
        end
    end

    // per-cell shift up for insert, shift down for delete
    always_comb
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            entries_next[j] = entries_reg[j];
            if (ins_ok)
            begin
                if (below[j])
                begin
                    entries_next[j] = entries_reg[j];
                end
                else if (j == 0)
                begin
                    entries_next[j] = item_reg.value;
                end
                else if (below[j-1])
                begin
                    entries_next[j] = item_reg.value;
                end
                else
                begin
                    entries_next[j] = entries_reg[j-1];
                end
            end
            else if (del_ok)
            begin
                if ((COUNT_W'(j) >= COUNT_W'(item_reg.position)) && (j + 1 < MAX_ENTRIES))
                begin
                    entries_next[j] = entries_reg[j+1];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
        result_next.count       = count_next;
        result_next.ok          = ins_ok || del_ok
                                  || ((item_reg.action == ACT_SEARCH) && hit);
        result_next.found_index = ((item_reg.action == ACT_SEARCH) && hit) ? hit_index : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_in;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                entries_reg[j] <= entries_next[j];
            end
        end
    end

    assign result = result_reg;
endmodule
`default_nettype wire
